@@ rtl/lptt_pkg.sv @@
package lptt_pkg;

  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_CAND   = 2'd1;
  localparam logic [1:0] MODE_VALUE  = 2'd2;

  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_VALUE = 3'd1;
  localparam logic [2:0] KIND_EOF   = 3'd2;
  localparam logic [2:0] KIND_EOR   = 3'd3;
  localparam logic [2:0] KIND_EOH   = 3'd4;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_H     = 8'h48;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_VALUE,
    OP_OPEN,
    OP_APPEND,
    OP_EOF,
    OP_NEXT,
    OP_END,
    OP_FLUSH,
    OP_REJ,
    OP_SH_RD,
    OP_SH_WR,
    OP_RESTART,
    OP_J_INIT,
    OP_IDX_RD,
    OP_J_EV,
    OP_MARK,
    OP_N_INIT,
    OP_N_EM,
    OP_N_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic take_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       is_lt;
    logic       is_gt;
    logic       cand_full;
    logic       cnt_zero;
    logic       rem_one;
    logic       emit_ok;
    logic       out_free;
    logic       pend_v;
    logic       more_replay;
    logic       shift_more;
    logic       stream_end;
    logic       j_done;
    logic       acc_mark;
    logic       acc_field;
    logic       c1_zero;
    logic       k_last;
    logic       len_zero;
  } dp_status_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) r = c - 8'd32;
    return r;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

@@ rtl/lptt_in_if.sv @@
interface lptt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

@@ rtl/lptt_out_if.sv @@
interface lptt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       truncated;
  logic       run_last;

  modport source (output valid, output kind, output out_byte, output truncated,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input out_byte, input truncated,
                  input run_last, output ready);
endinterface

@@ rtl/lptt_ram.sv @@
module lptt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/lptt_dp.sv @@
module lptt_dp #(
  parameter int unsigned NAME_BUFFER_BYTES = 64,
  parameter int unsigned LENGTH_BITS       = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lptt_pkg::dp_cmd_t   cmd_i,
  output lptt_pkg::dp_status_t st_o,
  input  logic [7:0]          data_byte_i,
  input  logic                stream_end_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [2:0]          kind_o,
  output logic [7:0]          out_byte_o,
  output logic                truncated_o,
  output logic                run_last_o
);
  import lptt_pkg::*;

  localparam int unsigned AW = $clog2(NAME_BUFFER_BYTES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LB = LENGTH_BITS;
  localparam logic [AW-1:0] CandLimit = AW'(NAME_BUFFER_BYTES - 1);
  localparam logic [LB+3:0] LenMax = {4'b0, {LB{1'b1}}};

  localparam logic [2:0] PH_NAME = 3'd0;
  localparam logic [2:0] PH_LWS  = 3'd1;
  localparam logic [2:0] PH_SGN  = 3'd2;
  localparam logic [2:0] PH_DIG  = 3'd3;
  localparam logic [2:0] PH_TYPE = 3'd4;
  localparam logic [2:0] PH_BAD  = 3'd5;

  // control state
  logic [1:0]    mode_q;
  logic [AW-1:0] count_q, rd_q;
  logic [CW-1:0] qlen_q, src_q, dst_q;
  logic          replay_q;
  logic [LB-1:0] rem_q;
  logic          pend_v_q, out_v_q, out_v_d;

  // payload
  logic [7:0]    in_byte_q, b_q;
  logic          end_q;
  logic [AW-1:0] idx_q, c1_q;
  logic [2:0]    ph_q;
  logic          neg_q, eor_q, eoh_q;
  logic [LB-1:0] plen_q;
  logic [2:0]    pend_kind_q, out_kind_q;
  logic [7:0]    pend_byte_q, out_byte_q;
  logic          pend_trunc_q, out_trunc_q, out_last_q;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata, cur;

  logic          e_v;
  logic [2:0]    e_kind;
  logic [7:0]    e_byte;
  logic          e_trunc;
  logic          out_free;
  logic [LB+3:0] acc_wide;
  logic [LB-1:0] acc;
  logic [7:0]    eor_ch, eoh_ch;

  lptt_ram #(.Width(8), .Depth(NAME_BUFFER_BYTES)) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cur      = replay_q ? rdata : in_byte_q;
  assign out_free = !out_v_q || out_ready_i;
  assign out_v_d  = (out_v_q && !out_ready_i) || (e_v && pend_v_q) || (cmd_i.op == OP_FLUSH);

  // decimal accumulate with saturation
  assign acc_wide = ({4'b0, plen_q} << 3) + ({4'b0, plen_q} << 1)
                  + {{(LB-4){1'b0}}, (rdata - CH_ZERO)};
  assign acc      = (acc_wide > LenMax) ? {LB{1'b1}} : acc_wide[LB-1:0];

  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    begin eor_ch = CH_E; eoh_ch = CH_E; end
      2'd1:    begin eor_ch = CH_O; eoh_ch = CH_O; end
      default: begin eor_ch = CH_R; eoh_ch = CH_H; end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = count_q;
    wdata = cur;
    raddr = rd_q;
    e_v     = 1'b0;
    e_kind  = KIND_EOF;
    e_byte  = 8'd0;
    e_trunc = 1'b0;
    unique case (cmd_i.op)
      OP_VALUE: begin
        e_v = 1'b1; e_kind = KIND_VALUE; e_byte = cur;
      end
      OP_APPEND: we = 1'b1;
      OP_EOF:    e_v = 1'b1;
      OP_END: begin
        e_v = (mode_q == MODE_VALUE); e_trunc = 1'b1;
      end
      OP_REJ: begin
        we = 1'b1; wdata = b_q;
      end
      OP_SH_RD: raddr = src_q[AW-1:0];
      OP_SH_WR: begin
        we = 1'b1; waddr = dst_q[AW-1:0]; wdata = rdata;
      end
      OP_IDX_RD: raddr = idx_q;
      OP_J_EV:   raddr = idx_q;
      OP_MARK: begin
        e_v = 1'b1; e_kind = eor_q ? KIND_EOR : KIND_EOH;
      end
      OP_N_EM: begin
        raddr = idx_q;
        e_v = 1'b1; e_kind = KIND_NAME; e_byte = upcase(rdata);
      end
      OP_N_DONE: e_v = (plen_q == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SEARCH;
      count_q  <= '0;
      rd_q     <= '0;
      qlen_q   <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      replay_q <= 1'b0;
      rem_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (e_v) pend_v_q <= 1'b1;
      unique case (cmd_i.op)
        OP_LOAD: begin
          replay_q <= 1'b0; rd_q <= '0;
        end
        OP_VALUE: begin
          rem_q <= rem_q - 1'b1;
          if (rem_q == LB'(1)) mode_q <= MODE_SEARCH;
        end
        OP_OPEN: begin
          mode_q <= MODE_CAND; count_q <= '0;
        end
        OP_APPEND: count_q <= count_q + 1'b1;
        OP_EOF:    mode_q <= MODE_SEARCH;
        OP_NEXT:   rd_q <= rd_q + 1'b1;
        OP_END: begin
          mode_q <= MODE_SEARCH; count_q <= '0; rem_q <= '0;
        end
        OP_FLUSH:  pend_v_q <= 1'b0;
        OP_REJ: begin
          src_q <= {1'b0, rd_q} + 1'b1;
          dst_q <= {1'b0, count_q} + 1'b1;
        end
        OP_SH_WR: begin
          src_q <= src_q + 1'b1;
          dst_q <= dst_q + 1'b1;
        end
        OP_RESTART: begin
          qlen_q <= dst_q; rd_q <= '0; replay_q <= 1'b1;
          count_q <= '0; mode_q <= MODE_SEARCH;
        end
        OP_MARK: begin
          mode_q <= MODE_SEARCH; count_q <= '0;
        end
        OP_N_DONE: begin
          count_q <= '0;
          if (plen_q == '0) mode_q <= MODE_SEARCH;
          else begin
            mode_q <= MODE_VALUE; rem_q <= plen_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) b_q <= cur;
    if (e_v) begin
      pend_kind_q  <= e_kind;
      pend_byte_q  <= e_byte;
      pend_trunc_q <= e_trunc;
      if (pend_v_q) begin
        out_kind_q  <= pend_kind_q;
        out_byte_q  <= pend_byte_q;
        out_trunc_q <= pend_trunc_q;
        out_last_q  <= 1'b0;
      end
    end
    unique case (cmd_i.op)
      OP_LOAD: begin
        in_byte_q <= data_byte_i; end_q <= stream_end_i;
      end
      OP_FLUSH: begin
        out_kind_q  <= pend_kind_q;
        out_byte_q  <= pend_byte_q;
        out_trunc_q <= pend_trunc_q;
        out_last_q  <= 1'b1;
      end
      OP_J_INIT: begin
        idx_q <= '0; ph_q <= PH_NAME; neg_q <= 1'b0;
        plen_q <= '0; eor_q <= 1'b1; eoh_q <= 1'b1;
      end
      OP_J_EV: begin
        idx_q <= idx_q + 1'b1;
        unique case (ph_q)
          PH_NAME: begin
            if (rdata == CH_COLON) begin
              c1_q <= idx_q; ph_q <= PH_LWS;
            end else if (idx_q < AW'(3)) begin
              eor_q <= eor_q && (upcase(rdata) == eor_ch);
              eoh_q <= eoh_q && (upcase(rdata) == eoh_ch);
            end
          end
          PH_LWS: begin
            if (is_ws(rdata)) ph_q <= PH_LWS;
            else if (rdata == CH_PLUS || rdata == CH_MINUS) begin
              neg_q <= (rdata == CH_MINUS); ph_q <= PH_SGN;
            end else if (is_digit(rdata)) begin
              plen_q <= acc; ph_q <= PH_DIG;
            end else ph_q <= PH_BAD;
          end
          PH_SGN, PH_DIG: begin
            if (is_digit(rdata)) begin
              plen_q <= acc; ph_q <= PH_DIG;
            end else if (ph_q == PH_DIG && rdata == CH_COLON) ph_q <= PH_TYPE;
            else ph_q <= PH_BAD;
          end
          default: ;
        endcase
      end
      OP_N_INIT: idx_q <= '0;
      OP_N_EM:   idx_q <= idx_q + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    st_o.mode        = mode_q;
    st_o.is_lt       = (cur == CH_LT);
    st_o.is_gt       = (cur == CH_GT);
    st_o.cand_full   = (count_q == CandLimit);
    st_o.cnt_zero    = (count_q == '0);
    st_o.rem_one     = (rem_q == LB'(1));
    st_o.emit_ok     = !pend_v_q || out_free;
    st_o.out_free    = out_free;
    st_o.pend_v      = pend_v_q;
    st_o.more_replay = replay_q && (({1'b0, rd_q} + 1'b1) < qlen_q);
    st_o.shift_more  = replay_q && (src_q < qlen_q);
    st_o.stream_end  = end_q;
    st_o.j_done      = (idx_q == count_q);
    st_o.acc_mark    = (ph_q == PH_NAME) && (count_q == AW'(3)) && (eor_q || eoh_q);
    st_o.acc_field   = ((ph_q == PH_DIG) || (ph_q == PH_TYPE)) && !(neg_q && plen_q != '0);
    st_o.c1_zero     = (c1_q == '0);
    st_o.k_last      = ((idx_q + 1'b1) == c1_q);
    st_o.len_zero    = (plen_q == '0);
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign truncated_o = out_trunc_q;
  assign run_last_o  = out_last_q;
endmodule

@@ rtl/lptt_ctrl.sv @@
module lptt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lptt_pkg::dp_status_t st_i,
  output lptt_pkg::dp_cmd_t    cmd_o
);
  import lptt_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_PROC  = 5'd2;
  localparam logic [4:0] S_NEXT  = 5'd3;
  localparam logic [4:0] S_EOF   = 5'd4;
  localparam logic [4:0] S_END   = 5'd5;
  localparam logic [4:0] S_FLUSH = 5'd6;
  localparam logic [4:0] S_REJ   = 5'd7;
  localparam logic [4:0] S_SHCHK = 5'd8;
  localparam logic [4:0] S_SHWR  = 5'd9;
  localparam logic [4:0] S_JINIT = 5'd10;
  localparam logic [4:0] S_JRD   = 5'd11;
  localparam logic [4:0] S_JEV   = 5'd12;
  localparam logic [4:0] S_JCHK  = 5'd13;
  localparam logic [4:0] S_MARK  = 5'd14;
  localparam logic [4:0] S_NRD   = 5'd15;
  localparam logic [4:0] S_NEM   = 5'd16;
  localparam logic [4:0] S_NDONE = 5'd17;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.op       = OP_NONE;
    cmd_o.take_byte = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = OP_LOAD; state_d = S_PROC;
      end
      S_RD: state_d = S_PROC;
      S_PROC: begin
        cmd_o.take_byte = 1'b1;
        priority case (st_i.mode)
          MODE_VALUE: if (st_i.emit_ok) begin
            cmd_o.op = OP_VALUE;
            state_d  = st_i.rem_one ? S_EOF : S_NEXT;
          end
          MODE_CAND: begin
            if (st_i.is_gt) state_d = st_i.cnt_zero ? S_REJ : S_JINIT;
            else if (!st_i.cand_full) begin
              cmd_o.op = OP_APPEND; state_d = S_NEXT;
            end else state_d = S_REJ;
          end
          default: begin
            if (st_i.is_lt) cmd_o.op = OP_OPEN;
            state_d = S_NEXT;
          end
        endcase
      end
      S_NEXT: begin
        if (st_i.more_replay) begin
          cmd_o.op = OP_NEXT; state_d = S_RD;
        end else state_d = S_END;
      end
      S_EOF: if (st_i.emit_ok) begin
        cmd_o.op = OP_EOF; state_d = S_NEXT;
      end
      S_END: begin
        if (!st_i.stream_end) state_d = S_FLUSH;
        else if (st_i.mode != MODE_VALUE || st_i.emit_ok) begin
          cmd_o.op = OP_END; state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!st_i.pend_v) state_d = S_IDLE;
        else if (st_i.out_free) begin
          cmd_o.op = OP_FLUSH; state_d = S_IDLE;
        end
      end
      S_REJ: begin
        cmd_o.op = OP_REJ; state_d = S_SHCHK;
      end
      S_SHCHK: begin
        if (st_i.shift_more) begin
          cmd_o.op = OP_SH_RD; state_d = S_SHWR;
        end else begin
          cmd_o.op = OP_RESTART; state_d = S_RD;
        end
      end
      S_SHWR: begin
        cmd_o.op = OP_SH_WR; state_d = S_SHCHK;
      end
      S_JINIT: begin
        cmd_o.op = OP_J_INIT; state_d = S_JRD;
      end
      S_JRD: begin
        cmd_o.op = OP_IDX_RD; state_d = S_JEV;
      end
      S_JEV: begin
        cmd_o.op = OP_J_EV; state_d = S_JCHK;
      end
      S_JCHK: begin
        if (!st_i.j_done) state_d = S_JRD;
        else if (st_i.acc_mark) state_d = S_MARK;
        else if (st_i.acc_field) begin
          cmd_o.op = OP_N_INIT;
          state_d  = st_i.c1_zero ? S_NDONE : S_NRD;
        end else state_d = S_REJ;
      end
      S_MARK: if (st_i.emit_ok) begin
        cmd_o.op = OP_MARK; state_d = S_NEXT;
      end
      S_NRD: begin
        cmd_o.op = OP_IDX_RD; state_d = S_NEM;
      end
      S_NEM: begin
        if (st_i.emit_ok) begin
          cmd_o.op = OP_N_EM;
          state_d  = st_i.k_last ? S_NDONE : S_NRD;
        end else cmd_o.op = OP_IDX_RD;
      end
      S_NDONE: if (st_i.len_zero == 1'b0 || st_i.emit_ok) begin
        cmd_o.op = OP_N_DONE; state_d = S_NEXT;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

@@ rtl/length_prefixed_tag_tokenizer_top.sv @@
// Tokenizer for <NAME:len[:type]>value tags and the bare <EOR>/<EOH> markers.
// Input bytes are taken one transaction at a time; each yields zero or more
// result transactions, the last of them flagged with run_last. A plain byte
// passes through the sequencer steps accept, process, advance, end check and
// hand-off. At a '>' the buffered candidate is parsed from the candidate RAM
// byte by byte and accepted names are replayed from it; a rejected candidate
// is copied back into the RAM byte by byte and rescanned, all through the
// single read port of that RAM. Each input byte is fully handled before the
// next is accepted. The block stalls when the output is not taken.
module length_prefixed_tag_tokenizer_top #(
  parameter int unsigned NAME_BUFFER_BYTES = 64,
  parameter int unsigned LENGTH_BITS       = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lptt_in_if.sink     in_i,
  lptt_out_if.source  out_o
);
  import lptt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  lptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  lptt_dp #(
    .NAME_BUFFER_BYTES (NAME_BUFFER_BYTES),
    .LENGTH_BITS       (LENGTH_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .data_byte_i  (in_i.data_byte),
    .stream_end_i (in_i.stream_end),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .kind_o       (out_o.kind),
    .out_byte_o   (out_o.out_byte),
    .truncated_o  (out_o.truncated),
    .run_last_o   (out_o.run_last)
  );
endmodule

@@ tb/length_prefixed_tag_tokenizer_top_test.sv @@
`timescale 1ns / 1ps

module length_prefixed_tag_tokenizer_top_test;
  import lptt_pkg::*;

  localparam int unsigned CAND_MAX  = 63;
  localparam int unsigned TOK_CAP   = 64;
  localparam logic [63:0] LEN_SAT   = 64'hFFFF_FFFF;
  localparam int unsigned IDLE_LIMIT = 100000;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    logic       trunc;
    logic       last;
  } token_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } sym_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       has_kind;
    logic [2:0] kind;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  lptt_in_if  in_if ();
  lptt_out_if out_if ();

  length_prefixed_tag_tokenizer_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  token_t     pending_tokens[$];
  sym_t       byte_stream[$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  logic [7:0] cand_buf[CAND_MAX];
  int         cand_n;
  logic [1:0] scan_mode;
  logic [63:0] value_left;
  int         step_tokens;

  // Tokenizer prediction
  function automatic void push_token(logic [2:0] k, logic [7:0] d, logic t);
    token_t tk;
    if (step_tokens >= TOK_CAP) return;
    tk.kind = k; tk.data = d; tk.trunc = t; tk.last = 1'b0;
    pending_tokens.push_back(tk);
    step_tokens++;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic bare_word(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return cand_n == 3 && to_upper(cand_buf[0]) == a && to_upper(cand_buf[1]) == b &&
           to_upper(cand_buf[2]) == c;
  endfunction

  function automatic logic close_tag();
    int colon1, len_end, i;
    logic neg;
    logic [63:0] len, d;
    if (cand_n == 0) return 1'b0;
    colon1 = cand_n;
    for (i = 0; i < cand_n; i++) if (cand_buf[i] == CH_COLON) begin colon1 = i; break; end
    if (colon1 == cand_n) begin
      if (bare_word(CH_E, CH_O, CH_R)) begin
        push_token(KIND_EOR, 8'h00, 1'b0); scan_mode = MODE_SEARCH; return 1'b1;
      end
      if (bare_word(CH_E, CH_O, CH_H)) begin
        push_token(KIND_EOH, 8'h00, 1'b0); scan_mode = MODE_SEARCH; return 1'b1;
      end
      return 1'b0;
    end
    len_end = cand_n;
    for (i = colon1 + 1; i < cand_n; i++)
      if (cand_buf[i] == CH_COLON) begin len_end = i; break; end
    i = colon1 + 1;
    while (i < len_end && is_space(cand_buf[i])) i++;
    neg = 1'b0;
    if (i < len_end && (cand_buf[i] == CH_PLUS || cand_buf[i] == CH_MINUS)) begin
      neg = cand_buf[i] == CH_MINUS;
      i++;
    end
    if (i >= len_end) return 1'b0;
    len = 64'd0;
    for (; i < len_end; i++) begin
      if (cand_buf[i] < CH_ZERO || cand_buf[i] > CH_NINE) return 1'b0;
      d = 64'(cand_buf[i] - CH_ZERO);
      if (len > (LEN_SAT - d) / 10) len = LEN_SAT;
      else len = len * 10 + d;
    end
    if (neg && len != 0) return 1'b0;
    for (i = 0; i < colon1; i++) push_token(KIND_NAME, to_upper(cand_buf[i]), 1'b0);
    if (len == 0) begin
      push_token(KIND_EOF, 8'h00, 1'b0);
      scan_mode = MODE_SEARCH;
    end else begin
      value_left = len;
      scan_mode = MODE_VALUE;
    end
    return 1'b1;
  endfunction

  function automatic void tokenize_byte(logic [7:0] din, logic fin);
    logic [7:0] work[$];
    logic [7:0] redo[$];
    logic [7:0] b;
    logic reject;
    step_tokens = 0;
    work.push_back(din);
    while (work.size() > 0) begin
      b = work.pop_front();
      if (scan_mode == MODE_VALUE) begin
        push_token(KIND_VALUE, b, 1'b0);
        value_left--;
        if (value_left == 0) begin
          push_token(KIND_EOF, 8'h00, 1'b0);
          scan_mode = MODE_SEARCH;
        end
      end else if (scan_mode == MODE_CAND) begin
        if (b == CH_GT) reject = !close_tag();
        else if (cand_n < CAND_MAX) begin
          cand_buf[cand_n++] = b;
          reject = 1'b0;
        end else reject = 1'b1;
        if (reject) begin
          // rescan from the byte after the rejected '<'
          redo = {};
          for (int k = 0; k < cand_n; k++) redo.push_back(cand_buf[k]);
          redo.push_back(b);
          work = {redo, work};
          scan_mode = MODE_SEARCH;
          cand_n = 0;
        end else if (b == CH_GT) cand_n = 0;
      end else if (b == CH_LT) begin
        scan_mode = MODE_CAND;
        cand_n = 0;
      end
    end
    if (fin) begin
      if (scan_mode == MODE_VALUE) push_token(KIND_EOF, 8'h00, 1'b1);
      scan_mode = MODE_SEARCH;
      cand_n = 0;
      value_left = 0;
    end
    if (step_tokens > 0) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
  endfunction

  // Result checking
  always @(posedge clk_i) begin
    token_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d byte=%02h", out_if.kind, out_if.out_byte);
      end else begin
        want = pending_tokens.pop_front();
        if (out_if.kind !== want.kind || out_if.out_byte !== want.data ||
            out_if.truncated !== want.trunc || out_if.run_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch kind/byte/trunc/last: exp %0d/%02h/%0b/%0b got %0d/%02h/%0b/%0b",
                     want.kind, want.data, want.trunc, want.last, out_if.kind,
                     out_if.out_byte, out_if.truncated, out_if.run_last);
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver stall pattern
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  task automatic put(logic [7:0] b, logic fin = 1'b0);
    sym_t s;
    s.data = b; s.last = fin;
    byte_stream.push_back(s);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'("a" + $urandom_range(0, 25));
    return $urandom_range(0, 1) ? c - 8'd32 : c;
  endfunction

  task automatic make_tag();
    int sel, len, nbytes;
    string ltxt;
    logic huge;
    sel = $urandom_range(0, 29);
    put(CH_LT);
    if (sel == 0) begin
      put_text("eOr"); put(CH_GT); return;
    end
    if (sel == 1) begin
      put_text("EoH"); put(CH_GT); return;
    end
    if (sel == 2) begin
      // may run past the candidate limit
      repeat ($urandom_range(60, 68)) put(8'($urandom_range(0, 255)));
      put(CH_GT);
      return;
    end
    repeat ($urandom_range(0, 6)) put(rand_letter());
    if (sel == 3) begin put(CH_GT); return; end
    put(CH_COLON);
    len = $urandom_range(0, 5);
    huge = 1'b0;
    case ($urandom_range(0, 9))
      6: begin
        if ($urandom_range(0, 1) != 0) ltxt = " \t";
        else ltxt = "\r";
        if ($urandom_range(0, 1) != 0) ltxt = {ltxt, "+"};
        ltxt = {ltxt, $sformatf("%0d", len)};
      end
      7: begin ltxt = "999999999999"; huge = 1'b1; end
      8: ltxt = $sformatf("%0dx", len);
      9: begin ltxt = $urandom_range(0, 1) ? "-0" : "-3"; if (ltxt == "-0") len = 0; end
      default: ltxt = $sformatf("%0d", len);
    endcase
    put_text(ltxt);
    if ($urandom_range(0, 2) == 0) begin put(CH_COLON); put_text("S"); end
    put(CH_GT);
    nbytes = huge ? $urandom_range(1, 4) : len;
    for (int i = 0; i < nbytes; i++)
      put(8'($urandom_range(0, 255)),
          (huge && i == nbytes - 1) || $urandom_range(0, 40) == 0);
  endtask

  row_t directed[] = '{
    '{"<", 0, 0, 0}, '{"e", 0, 0, 0}, '{"O", 0, 0, 0}, '{"r", 0, 0, 0},
    '{">", 0, 1, KIND_EOR},
    '{"<", 0, 0, 0}, '{"e", 0, 0, 0}, '{"o", 0, 0, 0}, '{"h", 0, 0, 0},
    '{">", 0, 1, KIND_EOH},
    '{"<", 0, 0, 0}, '{">", 0, 0, 0},
    '{"<", 0, 0, 0}, '{":", 0, 0, 0}, '{"-", 0, 0, 0}, '{"0", 0, 0, 0},
    '{">", 0, 1, KIND_EOF},
    '{"<", 0, 0, 0}, '{"a", 0, 0, 0}, '{":", 0, 0, 0}, '{"9", 0, 0, 0},
    '{">", 0, 0, 0}, '{8'hFF, 0, 0, 0}, '{8'h00, 1, 1, KIND_EOF}
  };

  task automatic send(sym_t s);
    in_if.valid <= 1'b1;
    in_if.data_byte <= s.data;
    in_if.stream_end <= s.last;
    do @(posedge clk_i); while (!in_if.ready);
    tokenize_byte(s.data, s.last);
    @(negedge clk_i);
  endtask

  initial begin
    sym_t s;
    int burst;
    in_if.valid = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.stream_end = 1'b0;
    cand_n = 0;
    scan_mode = MODE_SEARCH;
    value_left = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      s.data = directed[i].data;
      s.last = directed[i].last;
      send(s);
      if (directed[i].has_kind &&
          pending_tokens[pending_tokens.size() - 1].kind != directed[i].kind) begin
        mismatches++;
        if (mismatches <= 10) $display("directed row %0d: predicted kind differs", i);
      end
    end

    while (byte_stream.size() < 450) begin
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
      else make_tag();
    end
    put(8'h00, 1'b1);

    burst = 0;
    while (byte_stream.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) begin
          in_if.valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk_i);
        end
      end
      send(byte_stream.pop_front());
      burst--;
    end
    in_if.valid <= 1'b0;

    while (pending_tokens.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lptt_pkg.sv
rtl/lptt_in_if.sv
rtl/lptt_out_if.sv
rtl/lptt_ram.sv
rtl/lptt_dp.sv
rtl/lptt_ctrl.sv
rtl/length_prefixed_tag_tokenizer_top.sv
tb/length_prefixed_tag_tokenizer_top_test.sv
